/* sv/fat_chain_allocator_core_defines.svh */
// Assertion macros for the allocator RTL.
// No dependencies; include by bare file name.
`ifndef FAT_CHAIN_ALLOCATOR_CORE_DEFINES_SVH
`define FAT_CHAIN_ALLOCATOR_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define FCAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define FCAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/fcal_pkg.sv */
// Types, codes and sizes of the FAT chain allocator.
// No dependencies; used by fcal_ctrl, the top level and the test bench.
`default_nettype none
package fcal_pkg;

  localparam int FAT_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(FAT_ENTRIES);
  localparam int ENTRY_W     = 11;
  localparam int IDX_W       = 10;
  localparam int BS_W        = 16;
  localparam int BYTES_W     = 32;
  localparam int ACC_W       = BYTES_W + 1;

  localparam logic [ENTRY_W-1:0] END_MARK = '1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_END     = 2'd2;
  localparam logic [1:0] ST_CORRUPT = 2'd3;

  localparam logic CFG_BLK_BYTES = 1'b0;
  localparam logic CFG_USABLE    = 1'b1;

  localparam logic [BS_W-1:0]    BLK_BYTES_RST = 16'd1024;
  localparam logic [ENTRY_W-1:0] USABLE_RST    = 11'd1024;

  typedef enum logic [1:0] {
    FN_ALLOC  = 2'd0,
    FN_EXTEND = 2'd1,
    FN_TRUNC  = 2'd2,
    FN_LOOKUP = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK_RD,
    S_CHK_DT,
    S_SCAN,
    S_WALK,
    S_WALK_DT,
    S_TR_KEEP,
    S_TR_FREE,
    S_TR_FDT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [IDX_W-1:0]   start_block;
    logic [IDX_W-1:0]   count;
    logic [BYTES_W-1:0] byte_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   block;
    logic [ENTRY_W-1:0] blocks_done;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } ctrl_sts_t;

endpackage
`default_nettype wire

/* sv/fcal_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module fcal_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

/* sv/fcal_ctrl.sv */
// Request sequencer: clears the table, checks, walks and truncates chains, scans for free blocks.
// Depends on fcal_pkg; drives the ports of one fcal_ram.
`default_nettype none
module fcal_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire fcal_pkg::in_item_t          req,
  input  wire logic [fcal_pkg::BS_W-1:0]    bytes_per_blk,
  input  wire logic [fcal_pkg::ENTRY_W-1:0] usable_entries,
  input  wire logic                        res_take,
  output fcal_pkg::ctrl_sts_t              sts,
  output fcal_pkg::out_item_t              res,
  output logic                             ram_we,
  output logic [fcal_pkg::ADDR_W-1:0]      ram_waddr,
  output logic [fcal_pkg::ENTRY_W-1:0]     ram_wdata,
  output logic [fcal_pkg::ADDR_W-1:0]      ram_raddr,
  input  wire logic [fcal_pkg::ENTRY_W-1:0] ram_rdata
);

  localparam int AW = fcal_pkg::ADDR_W;
  localparam int EW = fcal_pkg::ENTRY_W;

  fcal_pkg::state_t  state_r, state_nxt;
  fcal_pkg::in_item_t req_r, req_nxt;
  fcal_pkg::out_item_t res_r, res_nxt;
  logic [EW-1:0] n_r, n_nxt;
  logic [fcal_pkg::BS_W-1:0] bs_r, bs_nxt;
  logic [EW-1:0] cur_r, cur_nxt;
  logic [EW-1:0] len_r, len_nxt;
  logic [EW-1:0] done_r, done_nxt;
  logic [fcal_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [EW-1:0] scan_r, scan_nxt;
  logic [EW-1:0] pidx_r, pidx_nxt;
  logic pend_r, pend_nxt;
  logic first_r, first_nxt;
  logic [fcal_pkg::IDX_W-1:0] blk0_r, blk0_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic is_alloc;
  logic want;
  logic [EW-1:0] cnt_p1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcal_pkg::S_CLEAR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    res_r   <= res_nxt;
    n_r     <= n_nxt;
    bs_r    <= bs_nxt;
    cur_r   <= cur_nxt;
    len_r   <= len_nxt;
    done_r  <= done_nxt;
    acc_r   <= acc_nxt;
    scan_r  <= scan_nxt;
    pidx_r  <= pidx_nxt;
    first_r <= first_nxt;
    blk0_r  <= blk0_nxt;
  end

  assign is_alloc = (req_r.func == fcal_pkg::FN_ALLOC);
  assign cnt_p1   = {1'b0, req_r.count} + EW'(1);
  assign want     = first_r ? 1'b1 :
                    is_alloc ? (acc_r < {1'b0, req_r.byte_size}) :
                    (done_r < {1'b0, req_r.count});

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    n_nxt     = n_r;
    bs_nxt    = bs_r;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    done_nxt  = done_r;
    acc_nxt   = acc_r;
    scan_nxt  = scan_r;
    pidx_nxt  = pidx_r;
    pend_nxt  = 1'b0;
    first_nxt = first_r;
    blk0_nxt  = blk0_r;
    clr_nxt   = clr_r;
    ram_we    = 1'b0;
    ram_waddr = cur_r[AW-1:0];
    ram_wdata = '0;
    ram_raddr = cur_r[AW-1:0];

    unique case (state_r)
      fcal_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(fcal_pkg::FAT_ENTRIES - 1)) begin
          state_nxt = fcal_pkg::S_IDLE;
        end
      end

      fcal_pkg::S_IDLE: begin
        if (start) begin
          req_nxt   = req;
          n_nxt     = (usable_entries > EW'(fcal_pkg::FAT_ENTRIES)) ?
                      EW'(fcal_pkg::FAT_ENTRIES) : usable_entries;
          bs_nxt    = (bytes_per_blk == '0) ? fcal_pkg::BS_W'(1) : bytes_per_blk;
          done_nxt  = '0;
          acc_nxt   = '0;
          scan_nxt  = EW'(1);
          res_nxt   = '0;
          if (req.func == fcal_pkg::FN_ALLOC) begin
            first_nxt = 1'b1;
            state_nxt = fcal_pkg::S_SCAN;
          end else begin
            first_nxt = 1'b0;
            cur_nxt   = {1'b0, req.start_block};
            len_nxt   = EW'(1);
            if (req.start_block == '0 || {1'b0, req.start_block} >= n_nxt) begin
              res_nxt.status = fcal_pkg::ST_CORRUPT;
              state_nxt      = fcal_pkg::S_FIN;
            end else begin
              state_nxt = fcal_pkg::S_CHK_RD;
            end
          end
        end
      end

      fcal_pkg::S_CHK_RD: begin
        state_nxt = fcal_pkg::S_CHK_DT;
      end

      fcal_pkg::S_CHK_DT: begin
        if (ram_rdata == fcal_pkg::END_MARK) begin
          // chain is sound: cur_r is its last block, len_r its length
          unique case (req_r.func)
            fcal_pkg::FN_EXTEND: begin
              state_nxt = fcal_pkg::S_SCAN;
            end
            fcal_pkg::FN_TRUNC: begin
              if (len_r < cnt_p1) begin
                res_nxt.status = fcal_pkg::ST_END;
                res_nxt.block  = cur_r[fcal_pkg::IDX_W-1:0];
                state_nxt      = fcal_pkg::S_FIN;
              end else begin
                cur_nxt   = {1'b0, req_r.start_block};
                state_nxt = fcal_pkg::S_WALK;
              end
            end
            fcal_pkg::FN_LOOKUP: begin
              if (len_r < cnt_p1) begin
                res_nxt.status      = fcal_pkg::ST_END;
                res_nxt.block       = cur_r[fcal_pkg::IDX_W-1:0];
                res_nxt.blocks_done = len_r - EW'(1);
                state_nxt           = fcal_pkg::S_FIN;
              end else begin
                cur_nxt   = {1'b0, req_r.start_block};
                state_nxt = fcal_pkg::S_WALK;
              end
            end
            default: begin
              state_nxt = fcal_pkg::S_FIN;
            end
          endcase
        end else if (ram_rdata == '0 || ram_rdata >= n_r || len_r >= n_r - EW'(1)) begin
          res_nxt.status = fcal_pkg::ST_CORRUPT;
          state_nxt      = fcal_pkg::S_FIN;
        end else begin
          cur_nxt   = ram_rdata;
          len_nxt   = len_r + EW'(1);
          state_nxt = fcal_pkg::S_CHK_RD;
        end
      end

      fcal_pkg::S_SCAN: begin
        if (!want) begin
          // enough blocks linked: close the chain
          ram_we              = 1'b1;
          ram_wdata           = fcal_pkg::END_MARK;
          res_nxt.status      = fcal_pkg::ST_OK;
          res_nxt.block       = is_alloc ? blk0_r : cur_r[fcal_pkg::IDX_W-1:0];
          res_nxt.blocks_done = is_alloc ? done_r + EW'(1) : done_r;
          state_nxt           = fcal_pkg::S_FIN;
        end else if (pend_r && ram_rdata == '0) begin
          // free block found; entries below it are all taken
          if (first_r) begin
            blk0_nxt  = pidx_r[fcal_pkg::IDX_W-1:0];
            first_nxt = 1'b0;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = pidx_r;
            done_nxt  = done_r + EW'(1);
            acc_nxt   = acc_r + {{(fcal_pkg::ACC_W - fcal_pkg::BS_W){1'b0}}, bs_r};
          end
          cur_nxt  = pidx_r;
          scan_nxt = pidx_r + EW'(1);
        end else if (scan_r < n_r) begin
          ram_raddr = scan_r[AW-1:0];
          pidx_nxt  = scan_r;
          pend_nxt  = 1'b1;
          scan_nxt  = scan_r + EW'(1);
        end else begin
          res_nxt.status = fcal_pkg::ST_FULL;
          if (first_r) begin
            res_nxt.block       = '0;
            res_nxt.blocks_done = '0;
          end else begin
            ram_we              = 1'b1;
            ram_wdata           = fcal_pkg::END_MARK;
            res_nxt.block       = is_alloc ? blk0_r : cur_r[fcal_pkg::IDX_W-1:0];
            res_nxt.blocks_done = is_alloc ? done_r + EW'(1) : done_r;
          end
          state_nxt = fcal_pkg::S_FIN;
        end
      end

      fcal_pkg::S_WALK: begin
        if (done_r == {1'b0, req_r.count}) begin
          res_nxt.block = cur_r[fcal_pkg::IDX_W-1:0];
          if (req_r.func == fcal_pkg::FN_LOOKUP) begin
            res_nxt.blocks_done = done_r;
            state_nxt           = fcal_pkg::S_FIN;
          end else begin
            state_nxt = fcal_pkg::S_TR_KEEP;
          end
        end else begin
          state_nxt = fcal_pkg::S_WALK_DT;
        end
      end

      fcal_pkg::S_WALK_DT: begin
        cur_nxt   = ram_rdata;
        done_nxt  = done_r + EW'(1);
        state_nxt = fcal_pkg::S_WALK;
      end

      fcal_pkg::S_TR_KEEP: begin
        // read of the kept block issued in S_WALK arrives now
        ram_we    = 1'b1;
        ram_wdata = fcal_pkg::END_MARK;
        cur_nxt   = ram_rdata;
        done_nxt  = '0;
        state_nxt = fcal_pkg::S_TR_FREE;
      end

      fcal_pkg::S_TR_FREE: begin
        if (cur_r == fcal_pkg::END_MARK || cur_r == '0 ||
            done_r >= EW'(fcal_pkg::FAT_ENTRIES)) begin
          res_nxt.blocks_done = done_r;
          state_nxt           = fcal_pkg::S_FIN;
        end else begin
          state_nxt = fcal_pkg::S_TR_FDT;
        end
      end

      fcal_pkg::S_TR_FDT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        cur_nxt   = ram_rdata;
        done_nxt  = done_r + EW'(1);
        state_nxt = fcal_pkg::S_TR_FREE;
      end

      fcal_pkg::S_FIN: begin
        if (res_take) begin
          state_nxt = fcal_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fcal_pkg::S_IDLE;
      end
    endcase
  end

  assign sts.idle      = (state_r == fcal_pkg::S_IDLE);
  assign sts.res_valid = (state_r == fcal_pkg::S_FIN);
  assign res           = res_r;

endmodule
`default_nettype wire

/* sv/fat_chain_allocator_core.sv */
// FAT chain allocator: top level with ports, configuration registers and output register.
// Depends on fcal_pkg, fcal_ram, fcal_ctrl and fat_chain_allocator_core_defines.svh.
//
// Usage:
//   in_*  : request item (func, start_block, count, byte_size); accepted when
//           in_valid is high and in_stall low. in_stall is high while a request
//           is being worked on, so one request is in flight at a time.
//   out_* : one result item per request (status, block, blocks_done), taken
//           when out_valid is high and out_stall low. While the receiver stalls,
//           the result holds in the output register; the next request is still
//           accepted and runs until its own result is ready.
//   cfg_* : bytes per block (index 0) and usable_entries (index 1); cfg_ready is
//           always high. Write only while no request is outstanding.
// Reset: configuration returns to 1024 / 1024 and the sequencer sweeps the
//   table to all free, one entry per cycle, with in_stall high.
// Work per request, bounded by the single table read port:
//   allocate/extend : a first-fit scan of the usable entries (one entry per
//                     cycle between free blocks found), linking each block found,
//                     after a check of every chain link for extend;
//   truncate/lookup : a check of every chain link, a walk of the links up to
//                     the count, and for truncate the freeing of the rest.
//   The result moves into the output register once the sequencer finishes.
`default_nettype none
`include "fat_chain_allocator_core_defines.svh"
module fat_chain_allocator_core (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire fcal_pkg::in_item_t       in_item,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output fcal_pkg::out_item_t           out_item,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic                     cfg_index,
  input  wire logic [fcal_pkg::BS_W-1:0] cfg_data
);

  logic [fcal_pkg::BS_W-1:0]    bytes_per_blk_r, bytes_per_blk_nxt;
  logic [fcal_pkg::ENTRY_W-1:0] usable_r, usable_nxt;
  logic                         out_valid_r, out_valid_nxt;
  fcal_pkg::out_item_t          out_r, out_nxt;

  fcal_pkg::ctrl_sts_t ctrl_sts;
  fcal_pkg::out_item_t ctrl_res;
  logic accept;
  logic res_take;

  logic                         ram_we;
  logic [fcal_pkg::ADDR_W-1:0]  ram_waddr;
  logic [fcal_pkg::ENTRY_W-1:0] ram_wdata;
  logic [fcal_pkg::ADDR_W-1:0]  ram_raddr;
  logic [fcal_pkg::ENTRY_W-1:0] ram_rdata;

  // Take new requests only when the sequencer is idle (also blocks during clearing).
  assign in_stall = !ctrl_sts.idle;
  assign accept   = in_valid && !in_stall;

  // Move a finished result into the output register once it is free or draining.
  assign res_take = ctrl_sts.res_valid && (!out_valid_r || !out_stall);

  assign cfg_ready = 1'b1;

  always_comb begin
    bytes_per_blk_nxt = bytes_per_blk_r;
    usable_nxt        = usable_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fcal_pkg::CFG_BLK_BYTES: bytes_per_blk_nxt = cfg_data;
        fcal_pkg::CFG_USABLE:    usable_nxt        = cfg_data[fcal_pkg::ENTRY_W-1:0];
        default:                 bytes_per_blk_nxt = bytes_per_blk_r;
      endcase
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (res_take) begin
      out_nxt       = ctrl_res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_per_blk_r <= fcal_pkg::BLK_BYTES_RST;
      usable_r        <= fcal_pkg::USABLE_RST;
      out_valid_r     <= 1'b0;
    end else begin
      bytes_per_blk_r <= bytes_per_blk_nxt;
      usable_r        <= usable_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  fcal_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (accept),
    .req            (in_item),
    .bytes_per_blk  (bytes_per_blk_r),
    .usable_entries (usable_r),
    .res_take       (res_take),
    .sts            (ctrl_sts),
    .res            (ctrl_res),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  fcal_ram #(
    .WIDTH (fcal_pkg::ENTRY_W),
    .DEPTH (fcal_pkg::FAT_ENTRIES)
  ) u_fat_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An accepted request must start the sequencer.
  `FCAL_ASSERT(a_accept_starts, accept |=> !ctrl_sts.idle, "accepted item did not start")
  // A result handed over must show on the output next cycle.
  `FCAL_ASSERT(a_take_shows, res_take |=> out_valid_r, "taken result not presented")
  // A stalled result holds its value.
  `FCAL_ASSERT(a_out_hold, out_valid_r && out_stall |=> out_valid_r && $stable(out_r), "stalled result changed")
  // After any reset cycle, neither the sequencer nor the output register presents a result.
  `FCAL_ASSERT_ALWAYS(a_no_res_rst, !rst_n |=> !ctrl_sts.res_valid && !out_valid_r, "result after reset")

endmodule
`default_nettype wire

/* sim/fat_chain_allocator_core_test.sv */
// Self-checking test of the FAT chain allocator: random and directed requests,
// predicted by a table model in the test. Depends on fcal_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module fat_chain_allocator_core_test;
  import fcal_pkg::*;

  localparam logic [10:0] TBL_END = 11'h7FF;

  // Table model and scoreboard: notes each accepted request, predicts its
  // result, and checks results against the oldest prediction.
  class fat_scoreboard;
    logic [10:0] table_q [FAT_ENTRIES];
    int unsigned blk_size;
    int unsigned usable;
    out_item_t pending [$];
    int mismatches;

    function void clear_table();
      foreach (table_q[i]) table_q[i] = '0;
      blk_size = 1024;
      usable = 1024;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == CFG_BLK_BYTES) blk_size = val;
      else usable = val[10:0];
    endfunction

    function int unsigned lim();
      return usable > FAT_ENTRIES ? FAT_ENTRIES : usable;
    endfunction

    function int unsigned first_free(int unsigned skip);
      for (int unsigned i = 1; i < lim(); i++)
        if (table_q[i] == 0 && i != skip) return i;
      return 0;
    endfunction

    // Walk the chain; fail on a free or out-of-range link or an overlong chain.
    function bit chain_ok(int unsigned start, output int unsigned len,
                          output int unsigned last);
      int unsigned n, cur, cnt, v;
      n = lim();
      cur = start;
      cnt = 1;
      len = 0;
      last = 0;
      if (start == 0 || start >= n) return 0;
      forever begin
        v = table_q[cur];
        if (v == TBL_END) break;
        if (v == 0 || v >= n || cnt >= n - 1) return 0;
        cur = v;
        cnt++;
      end
      len = cnt;
      last = cur;
      return 1;
    endfunction

    function void note_request(in_item_t it);
      out_item_t r;
      longint unsigned bs, need, got;
      int unsigned cur, nb, len, last, keep, nx, done, k;
      r = '0;
      done = 0;
      if (func_t'(it.func) == FN_ALLOC) begin
        bs = (blk_size == 0) ? 1 : blk_size;
        need = (longint'(it.byte_size) + bs - 1) / bs;
        got = 0;
        cur = first_free(0);
        if (cur == 0) r.status = ST_FULL;
        else begin
          r.block = cur;
          while (got < need) begin
            nb = first_free(cur);
            if (nb == 0) begin
              r.status = ST_FULL;
              break;
            end
            table_q[cur] = nb;
            cur = nb;
            got++;
          end
          table_q[cur] = TBL_END;
          done = got + 1;
        end
      end else if (!chain_ok(it.start_block, len, last)) begin
        r.status = ST_CORRUPT;
      end else if (func_t'(it.func) == FN_EXTEND) begin
        while (done < it.count) begin
          nb = first_free(last);
          if (nb == 0) begin
            r.status = ST_FULL;
            break;
          end
          table_q[last] = nb;
          last = nb;
          done++;
        end
        table_q[last] = TBL_END;
        r.block = last;
      end else if (func_t'(it.func) == FN_TRUNC) begin
        if (len < it.count + 1) begin
          r.status = ST_END;
          r.block = last;
        end else begin
          keep = it.start_block;
          for (k = 0; k < it.count; k++) keep = table_q[keep];
          cur = table_q[keep];
          table_q[keep] = TBL_END;
          while (cur != TBL_END && cur != 0 && done < FAT_ENTRIES) begin
            nx = table_q[cur];
            table_q[cur] = 0;
            cur = nx;
            done++;
          end
          r.block = keep;
        end
      end else begin
        if (len < it.count + 1) begin
          r.status = ST_END;
          r.block = last;
          done = len - 1;
        end else begin
          cur = it.start_block;
          for (k = 0; k < it.count; k++) cur = table_q[cur];
          r.block = cur;
          done = it.count;
        end
      end
      r.blocks_done = done;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.block !== exp.block ||
          got.blocks_done !== exp.blocks_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_item;
  out_item_t out_item;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [BS_W-1:0] cfg_data;

  fat_scoreboard fat_model;
  int send_idle_pct, recv_idle_pct;
  int unsigned live_chains [$];

  fat_chain_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Run limit: several times the worst case per request
  // (full chain check, walk and free) plus stalls.
  initial begin
    #200_000_000;
    $display("fat_chain_allocator_core_test failed");
    $finish;
  end

  // Receiver: stall at random, check every result taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) fat_model.check_result(out_item);
  end
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Drive one request; idle first at random, hold until taken. Valid stays
  // high after the handshake until the next idle cycle or a drain.
  task automatic send_request(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    fat_model.note_request(it);
    @(negedge clk);
  endtask

  // Drop valid, hold until every predicted result has come, then settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (fat_model.pending.size() != 0) @(negedge clk);
    repeat (3000) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    fat_model.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t make_req(func_t f, int unsigned sb, int unsigned cnt,
                                        logic [31:0] bytes);
    in_item_t it;
    it.func = f;
    it.start_block = sb;
    it.count = cnt;
    it.byte_size = bytes;
    return it;
  endfunction

  // Random request, mostly aimed at chains known to exist.
  function automatic in_item_t rand_req();
    in_item_t it;
    int unsigned pick;
    it = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.func = FN_ALLOC;
      if ($urandom_range(9) != 0) it.byte_size = $urandom_range(fat_model.blk_size * 12);
    end else begin
      it.func = func_t'($urandom_range(3, 1));
      if (live_chains.size() != 0 && pick < 90)
        it.start_block = live_chains[$urandom_range(live_chains.size() - 1)];
      if ($urandom_range(7) != 0) it.count = $urandom_range(12);
    end
    return it;
  endfunction

  task automatic random_phase(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = rand_req();
      if (func_t'(it.func) == FN_ALLOC) begin
        send_request(it);
        if (fat_model.pending[$].blocks_done != 0)
          live_chains.push_back(fat_model.pending[$].block);
      end else send_request(it);
      if (live_chains.size() > 40) void'(live_chains.pop_front());
    end
  endtask

  initial begin
    fat_model = new();
    fat_model.clear_table();
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = CFG_BLK_BYTES;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every function, extremes, corrupt and past-end cases.
    send_request(make_req(FN_ALLOC, 0, 0, 0));
    send_request(make_req(FN_ALLOC, 1023, 1023, 32'd3000));
    send_request(make_req(FN_LOOKUP, 2, 0, 0));
    send_request(make_req(FN_LOOKUP, 2, 3, 32'hFFFF_FFFF));
    send_request(make_req(FN_LOOKUP, 2, 1023, 0));
    send_request(make_req(FN_EXTEND, 2, 5, 0));
    send_request(make_req(FN_TRUNC, 2, 1, 0));
    send_request(make_req(FN_TRUNC, 2, 1023, 0));
    send_request(make_req(FN_LOOKUP, 0, 0, 0));
    send_request(make_req(FN_EXTEND, 1023, 1, 0));
    send_request(make_req(FN_TRUNC, 900, 0, 0));
    send_request(make_req(FN_EXTEND, 1, 0, 0));
    drain();

    // Small table: fill it up to hit the full status, both partial and total.
    write_reg(CFG_USABLE, 16'd8);
    write_reg(CFG_BLK_BYTES, 16'd0);
    send_request(make_req(FN_ALLOC, 0, 0, 32'hFFFF_FFFF));
    send_request(make_req(FN_ALLOC, 0, 0, 32'd1));
    send_request(make_req(FN_EXTEND, 1, 3, 0));
    send_request(make_req(FN_TRUNC, 1, 0, 0));
    send_request(make_req(FN_EXTEND, 1, 1023, 0));
    send_request(make_req(FN_LOOKUP, 9, 0, 0));
    drain();
    write_reg(CFG_USABLE, 16'd2);
    send_request(make_req(FN_ALLOC, 0, 0, 32'd5));
    send_request(make_req(FN_LOOKUP, 1, 0, 0));
    drain();

    // Random phases over several settings and idle patterns.
    write_reg(CFG_USABLE, 16'd64);
    write_reg(CFG_BLK_BYTES, 16'd1);
    live_chains.delete();
    send_idle_pct = 33;
    recv_idle_pct = 56;
    random_phase(190);
    drain();

    write_reg(CFG_USABLE, 16'd1024);
    write_reg(CFG_BLK_BYTES, 16'hFFFF);
    send_idle_pct = 56;
    recv_idle_pct = 33;
    random_phase(190);
    drain();

    write_reg(CFG_USABLE, 16'd2047);
    write_reg(CFG_BLK_BYTES, 16'd512);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(190);
    drain();

    if (fat_model.mismatches == 0 && fat_model.pending.size() == 0)
      $display("fat_chain_allocator_core_test passed");
    else
      $display("fat_chain_allocator_core_test failed");
    $finish;
  end
endmodule

/* files.f */
+incdir+sv
sv/fcal_pkg.sv
sv/fcal_ram.sv
sv/fcal_ctrl.sv
sv/fat_chain_allocator_core.sv
sim/fat_chain_allocator_core_test.sv
